[design/skt_pkg.sv]
package skt_pkg;

  localparam int KEY_W         = 32;
  localparam int OP_W          = 2;
  localparam int ENTRY_COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD,
    ST_DN_WR
  } state_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    pos_take;
    logic    rd_en;
    logic    rd_prev;
    logic    wr_en;
    logic    wr_prev;
    logic    wr_key;
    cnt_op_t cnt_op;
    logic    finish;
    logic    res_hit;
    logic    res_drop;
  } cmd_t;

  typedef struct packed {
    logic at_count;
    logic at_pos;
    logic full;
    logic less;
    logic equal;
  } status_t;

endpackage

[design/skt_ram.sv]
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/skt_ctrl.sv]
module skt_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [skt_pkg::OP_W-1:0]    operation,
  input  skt_pkg::status_t            status,
  output skt_pkg::cmd_t               cmd,
  output logic                        busy
);

  import skt_pkg::*;

  state_t          state;
  state_t          state_next;
  logic [OP_W-1:0] op;

  logic idle_accept;
  logic idle_finish;

  assign idle_accept = start && (state == ST_IDLE);
  assign idle_finish = ((operation == OP_INSERT) && status.full) ||
                       !((operation == OP_INSERT) || (operation == OP_LOOKUP) ||
                         (operation == OP_REMOVE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (idle_accept) begin
      op <= operation;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && !idle_finish) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (!status.at_count) begin
          state_next = ST_SCAN_CMP;
        end else if (op == OP_INSERT) begin
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_CMP: begin
        if (status.less) begin
          state_next = ST_SCAN_RD;
        end else if (op == OP_INSERT) begin
          state_next = ST_UP_RD;
        end else if ((op == OP_REMOVE) && status.equal) begin
          state_next = ST_DN_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_UP_RD: begin
        state_next = status.at_pos ? ST_IDLE : ST_UP_WR;
      end
      ST_UP_WR: begin
        state_next = ST_UP_RD;
      end
      ST_DN_RD: begin
        state_next = status.at_count ? ST_IDLE : ST_DN_WR;
      end
      ST_DN_WR: begin
        state_next = ST_DN_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '{load: 1'b0, idx_op: IDX_HOLD, pos_take: 1'b0, rd_en: 1'b0,
            rd_prev: 1'b0, wr_en: 1'b0, wr_prev: 1'b0, wr_key: 1'b0,
            cnt_op: CNT_HOLD, finish: 1'b0, res_hit: 1'b0, res_drop: 1'b0};
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (idle_finish) begin
            cmd.finish   = 1'b1;
            cmd.res_drop = (operation == OP_INSERT);
          end
        end
      end
      ST_SCAN_RD: begin
        if (!status.at_count) begin
          cmd.rd_en = 1'b1;
        end else if (op == OP_INSERT) begin
          cmd.pos_take = 1'b1;
          cmd.idx_op   = IDX_COUNT;
        end else begin
          cmd.finish = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        if (status.less) begin
          cmd.idx_op = IDX_INC;
        end else if (op == OP_INSERT) begin
          cmd.pos_take = 1'b1;
          cmd.idx_op   = IDX_COUNT;
        end else if ((op == OP_REMOVE) && status.equal) begin
          // step past the match, then pull the tail down
          cmd.idx_op = IDX_INC;
        end else begin
          cmd.finish  = 1'b1;
          cmd.res_hit = status.equal;
        end
      end
      ST_UP_RD: begin
        if (status.at_pos) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_key  = 1'b1;
          cmd.cnt_op  = CNT_INC;
          cmd.finish  = 1'b1;
          cmd.res_hit = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
        end
      end
      ST_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
      end
      ST_DN_RD: begin
        if (status.at_count) begin
          cmd.cnt_op  = CNT_DEC;
          cmd.finish  = 1'b1;
          cmd.res_hit = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_DN_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_prev = 1'b1;
        cmd.idx_op  = IDX_INC;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/skt_datapath.sv]
module skt_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [skt_pkg::KEY_W-1:0]     search_key,
  input  skt_pkg::cmd_t                        cmd,
  output skt_pkg::status_t                     status,
  output logic                                 done,
  output logic                                 hit,
  output logic                                 full_drop,
  output logic [skt_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

  import skt_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  logic signed [KEY_W-1:0] key;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        pos;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx_prev;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [KEY_W-1:0]        wr_data;
  logic [ADDR_W-1:0]       rd_addr;
  logic [KEY_W-1:0]        rd_data;

  assign idx_prev = idx - CNT_W'(1);
  assign rd_addr  = cmd.rd_prev ? idx_prev[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign wr_addr  = cmd.wr_prev ? idx_prev[ADDR_W-1:0] : idx[ADDR_W-1:0];
  assign wr_data  = cmd.wr_key ? key : rd_data;
  assign wr_en    = cmd.wr_en;

  skt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key <= search_key;
    end
    if (cmd.pos_take) begin
      pos <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
    end else begin
      case (cmd.idx_op)
        IDX_INC:   idx <= idx + CNT_W'(1);
        IDX_DEC:   idx <= idx_prev;
        IDX_COUNT: idx <= count;
        default:   idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit       <= cmd.res_hit;
      full_drop <= cmd.res_drop;
    end
  end

  assign entry_count = ENTRY_COUNT_W'(count);

  assign status.at_count = (idx == count);
  assign status.at_pos   = (idx == pos);
  assign status.full     = (count == CNT_W'(CAPACITY));
  assign status.less     = ($signed(rd_data) < key);
  assign status.equal    = ($signed(rd_data) == key);

endmodule

[design/sorted_key_table_core.sv]
// Sorted key table: up to CAPACITY signed 32-bit keys held in ascending
// order in one RAM, duplicates allowed.
// Request channel: start with operation and search_key is taken on a
// rising edge where busy is low. busy stays high while the request runs.
// Operation insert, lookup or remove; the unused code changes nothing.
// Result channel: done is high for one cycle with hit, full_drop and
// entry_count; the receiver cannot stall, so each beat must be taken then.
// Steps, with n stored keys and p the first place whose key is not
// smaller than the request key: the scan reads one entry at a time
// through the RAM's registered read port up to place p, then lookup
// reports; insert moves the tail (places p to n-1) up one place and
// writes the key at p; remove pulls the tail after p down one place.
// An insert into a full table and the unused code report without a
// scan. A new request can be started in the cycle that done is shown.
// One request at a time; the single RAM port pair bounds the rate.
// Reset empties the table at once (count to zero); no clearing pass.
module sorted_key_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [skt_pkg::OP_W-1:0]             operation,
  input  logic signed [skt_pkg::KEY_W-1:0]     search_key,
  output logic                                 done,
  output logic                                 hit,
  output logic                                 full_drop,
  output logic [skt_pkg::ENTRY_COUNT_W-1:0]    entry_count
);

  import skt_pkg::*;

  cmd_t    cmd;
  status_t status;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .operation(operation),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  skt_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .search_key (search_key),
    .cmd        (cmd),
    .status     (status),
    .done       (done),
    .hit        (hit),
    .full_drop  (full_drop),
    .entry_count(entry_count)
  );

endmodule
